// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define PLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define PLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Types and constants shared by the positional insert list and its cells.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int DATA_W = 32;
  localparam int SLOT_W = 8;
  localparam int ARITH_W = 9;
  localparam int LEN_W = 7;
  localparam int IN_W = 48;
  localparam int OUT_W = 48;

  localparam logic signed [DATA_W-1:0] REMOVE_EMPTY = -32'sd1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_POP_EMPTY    = 2'd1,
    ST_FULL_DROP    = 2'd2,
    ST_EMPTY_IGNORE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic [SLOT_W-1:0]          slot;
    logic signed [DATA_W-1:0]   value;
  } cell_cmd_t;

endpackage

// ===== src/plc_cell.sv =====
// ----------------------------------------------------------------------------
// plc_cell
// One list entry. Cells are numbered from the tail, so cell 0 holds the tail.
// ----------------------------------------------------------------------------
module plc_cell #(
  parameter int INDEX = 0
) (
  input  logic                               clk,
  input  plc_pkg::cell_cmd_t                 cmd,
  input  logic signed [plc_pkg::DATA_W-1:0]  lower,
  input  logic signed [plc_pkg::DATA_W-1:0]  upper,
  output logic signed [plc_pkg::DATA_W-1:0]  data
);
  import plc_pkg::*;

  localparam logic [SLOT_W-1:0] IDX = SLOT_W'(INDEX);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (IDX > cmd.slot) begin
          data <= lower;
        end else if (IDX == cmd.slot) begin
          data <= cmd.value;
        end
      end
      CELL_POP: begin
        data <= upper;
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

// ===== src/positional_insert_list.sv =====
// ----------------------------------------------------------------------------
// positional_insert_list
// Bounded ordered list of signed values kept in a chain of shifting cells.
// ----------------------------------------------------------------------------
//  Channel   Dir  Fields (lowest bit first)
//  s_axis    in   opcode[1:0], value[33:2], position[41:34]
//  m_axis    out  removed_value[31:0], status[33:32], length[40:34]
//
//  One item is accepted per cycle while no stalled result waits at the output.
//  The result appears in the output register on the cycle after acceptance.
//  All cells shift together, so list length does not change the timing.
//  A stalled result blocks input only until it is taken.
//  Reset empties the list and clears the output register's valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_insert_list #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // opcode, value, position
  input  logic [plc_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // removed_value, status, length
  output logic [plc_pkg::OUT_W-1:0] m_tdata
);
  import plc_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_removed;
  status_t                   out_status;

  logic                      s_fire;
  opcode_t                   op;
  logic signed [DATA_W-1:0]  in_value;
  logic [SLOT_W-1:0]         in_pos;
  logic [ARITH_W-1:0]        cnt9;
  logic [ARITH_W-1:0]        pos_m1;
  logic                      full;
  logic                      empty;
  cell_cmd_t                 cmd;
  logic signed [DATA_W-1:0]  removed;
  status_t                   status;

  logic signed [DATA_W-1:0]  cell_data [CAPACITY];

  assign s_fire   = s_tvalid && s_tready;
  assign s_tready = !out_valid || m_tready;
  assign op       = opcode_t'(s_tdata[1:0]);
  assign in_value = s_tdata[33:2];
  assign in_pos   = s_tdata[41:34];
  assign cnt9     = ARITH_W'(count);
  assign pos_m1   = ARITH_W'(in_pos) - ARITH_W'(1);
  assign full     = (cnt9 >= ARITH_W'(CAPACITY));
  assign empty    = (count == '0);

  always_comb begin
    cmd.op     = CELL_HOLD;
    cmd.slot   = '0;
    cmd.value  = in_value;
    removed    = '0;
    status     = ST_DONE;
    count_next = count;
    case (op)
      OP_APPEND: begin
        if (full) begin
          status = ST_FULL_DROP;
        end else begin
          cmd.op     = CELL_INSERT;
          count_next = count + CW'(1);
        end
      end
      OP_INSERT: begin
        if (empty) begin
          if (in_pos == SLOT_W'(1)) begin
            cmd.op     = CELL_INSERT;
            count_next = count + CW'(1);
          end else begin
            status = ST_EMPTY_IGNORE;
          end
        end else if (full) begin
          status = ST_FULL_DROP;
        end else begin
          cmd.op     = CELL_INSERT;
          count_next = count + CW'(1);
          if (in_pos == '0) begin
            cmd.slot = SLOT_W'(cnt9 - ARITH_W'(1));
          end else if (pos_m1 < cnt9) begin
            cmd.slot = SLOT_W'(cnt9 - pos_m1);
          end
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          removed = REMOVE_EMPTY;
          status  = ST_POP_EMPTY;
        end else begin
          cmd.op     = CELL_POP;
          removed    = cell_data[0];
          count_next = count - CW'(1);
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
    if (!s_fire) begin
      cmd.op     = CELL_HOLD;
      count_next = count;
    end
  end

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [DATA_W-1:0] lower;
    logic signed [DATA_W-1:0] upper;
    if (j == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[j+1];
    end
    plc_cell #(
      .INDEX (j)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .lower (lower),
      .upper (upper),
      .data  (cell_data[j])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (s_fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_removed <= removed;
      out_status  <= status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, LEN_W'(count), out_status, out_removed};

  `PLC_ASSERT(a_count_bound, count <= CW'(CAPACITY), "list count exceeds capacity")
  `PLC_ASSERT(a_fire_result, s_fire |=> m_tvalid, "accepted item produced no result")
  `PLC_ASSERT(a_len_match, m_tvalid |-> (m_tdata[40:34] == LEN_W'(count)), "length mismatch")
  `PLC_ASSERT(a_hold_count, !s_fire |=> $stable(count), "count changed without an item")
  `PLC_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_tvalid, "result valid after reset")

endmodule

// ===== dv/positional_insert_list_chk.sv =====
// ----------------------------------------------------------------------------
// positional_insert_list_chk
// Watches both stream channels of the positional insert list, keeps its own
// copy of the list, predicts one result per accepted item and compares every
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module positional_insert_list_chk #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  // opcode, value, position
  input  logic [plc_pkg::IN_W-1:0]   s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  // removed_value, status, length
  input  logic [plc_pkg::OUT_W-1:0]  m_tdata,
  output int                         fail_count,
  output int                         pending
);
  import plc_pkg::*;

  typedef struct {
    logic signed [DATA_W-1:0] removed_value;
    status_t                  status;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  logic signed [DATA_W-1:0] list_vals[$];
  list_result_t             expected_results[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic list_result_t apply_list_op(opcode_t op, logic signed [DATA_W-1:0] v,
                                                 logic [SLOT_W-1:0] pos);
    list_result_t res;
    int           idx;
    res.removed_value = '0;
    res.status = ST_DONE;
    case (op)
      OP_APPEND: begin
        if (list_vals.size() >= CAPACITY) res.status = ST_FULL_DROP;
        else list_vals.push_back(v);
      end
      OP_INSERT: begin
        if (list_vals.size() == 0) begin
          if (pos == 8'd1) list_vals.push_back(v);
          else res.status = ST_EMPTY_IGNORE;
        end else if (list_vals.size() >= CAPACITY) begin
          res.status = ST_FULL_DROP;
        end else begin
          // Position zero lands just after the head; past the end goes to the tail.
          idx = (pos == 8'd0) ? 1 : int'(pos) - 1;
          if (idx > list_vals.size()) idx = list_vals.size();
          list_vals.insert(idx, v);
        end
      end
      OP_REMOVE: begin
        if (list_vals.size() == 0) begin
          res.removed_value = REMOVE_EMPTY;
          res.status = ST_POP_EMPTY;
        end else begin
          res.removed_value = list_vals.pop_back();
        end
      end
      default: ;
    endcase
    res.length = LEN_W'(list_vals.size());
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t exp_res;
    logic signed [DATA_W-1:0] act_removed;
    status_t act_status;
    logic [LEN_W-1:0] act_length;
    if (rst) begin
      list_vals.delete();
      expected_results.delete();
    end else begin
      act_removed = m_tdata[31:0];
      act_status = status_t'(m_tdata[33:32]);
      act_length = m_tdata[40:34];
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("Unexpected result: removed_value %0d status %0d length %0d",
                 act_removed, act_status, act_length);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (act_removed !== exp_res.removed_value) begin
            $error("removed_value: expected %0d, got %0d", exp_res.removed_value,
                   act_removed);
            fail_count++;
          end
          if (act_status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, act_status);
            fail_count++;
          end
          if (act_length !== exp_res.length) begin
            $error("length: expected %0d, got %0d", exp_res.length, act_length);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_list_op(opcode_t'(s_tdata[1:0]),
                                                 s_tdata[33:2], s_tdata[41:34]));
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== dv/tb_positional_insert_list.sv =====
// ----------------------------------------------------------------------------
// tb_positional_insert_list
// Drives the positional insert list with a directed opening covering the
// field extremes, every operation and the empty and position corner
// cases, then with random runs that grow the list to full and drain it,
// under varying idle patterns on both channels. A checker predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_positional_insert_list;
  import plc_pkg::*;

  localparam int CAP = 64;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // opcode, value, position
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // removed_value, status, length
  logic [OUT_W-1:0]  m_tdata;
  int                fail_count;
  int                pending;
  int                send_idle_pct = 19;
  int                recv_idle_pct = 79;

  always #5 clk = ~clk;

  positional_insert_list #(.CAPACITY(CAP)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  positional_insert_list_chk #(.CAPACITY(CAP)) u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input opcode_t op, input logic [DATA_W-1:0] v,
                           input logic [SLOT_W-1:0] pos);
    s_tdata <= {6'b0, pos, v, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
  endtask

  task automatic run_random(input int n);
    int                mode;
    int                mode_left;
    int                roll;
    opcode_t           op;
    logic [DATA_W-1:0] v;
    logic [SLOT_W-1:0] pos;
    mode = 0;
    mode_left = 0;
    for (int i = 0; i < n; i++) begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 120);
      end
      mode_left--;
      roll = $urandom_range(0, 99);
      // Mode 0 fills the list toward full, mode 1 drains it, mode 2 mixes.
      case (mode)
        0: op = (roll < 3) ? OP_NONE : (roll < 9) ? OP_REMOVE :
                (roll < 55) ? OP_APPEND : OP_INSERT;
        1: op = (roll < 3) ? OP_NONE : (roll < 75) ? OP_REMOVE :
                (roll < 88) ? OP_APPEND : OP_INSERT;
        default: op = (roll < 3) ? OP_NONE : (roll < 40) ? OP_REMOVE :
                      (roll < 70) ? OP_APPEND : OP_INSERT;
      endcase
      case ($urandom_range(0, 9))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        3: v = 32'hffff_ffff;
        default: v = $urandom();
      endcase
      case ($urandom_range(0, 9))
        0: pos = 8'd0;
        1: pos = 8'd1;
        2: pos = 8'd255;
        3, 4, 5, 6: pos = SLOT_W'($urandom_range(0, CAP + 2));
        default: pos = SLOT_W'($urandom_range(0, 255));
      endcase
      send_item(op, v, pos);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(OP_REMOVE, 32'h0, 8'd0);
    send_item(OP_INSERT, 32'h1234_5678, 8'd0);
    send_item(OP_INSERT, 32'h1234_5678, 8'd7);
    send_item(OP_INSERT, 32'h7fff_ffff, 8'd1);
    send_item(OP_APPEND, 32'h8000_0000, 8'd255);
    send_item(OP_APPEND, 32'hffff_ffff, 8'd0);
    send_item(OP_INSERT, 32'h0000_0000, 8'd0);
    send_item(OP_INSERT, 32'h0000_007b, 8'd255);
    send_item(OP_INSERT, 32'h5555_5555, 8'd2);
    send_item(OP_INSERT, 32'haaaa_aaaa, 8'd1);
    send_item(OP_NONE, 32'hffff_ffff, 8'd255);
    repeat (8) send_item(OP_REMOVE, 32'hffff_ffff, 8'd255);

    run_random(240);
    send_idle_pct = 79;
    recv_idle_pct = 19;
    run_random(230);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(230);

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS positional_insert_list");
    end else begin
      $display("FAIL positional_insert_list");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL positional_insert_list");
    $finish;
  end

endmodule
